[sv/ssd_pkg.sv]
// shared types and constants for the segment-to-segment distance block
`default_nettype none
package ssd_pkg;
   localparam int CoordW = 32;
   localparam int VecW   = 33;
   localparam int DotW   = 68;
   localparam int WideW  = 140;
   localparam int QBits  = 32;
   localparam int DistW  = 34;
   localparam int RootW  = 36;
   localparam int QueueDepth = 4;

   localparam int DotA = 0;
   localparam int DotB = 1;
   localparam int DotC = 2;
   localparam int DotD = 3;
   localparam int DotE = 4;

   typedef struct packed {
      logic [2:0][VecW-1:0] u;
      logic [2:0][VecW-1:0] v;
      logic [2:0][VecW-1:0] w;
   } vecs_type;

   typedef struct packed {
      vecs_type             vec;
      logic [4:0][DotW-1:0] dot;
   } item_type;
endpackage
`default_nettype wire

[sv/ssd_front.sv]
// front end: input register, difference vectors and the five dot products
`default_nettype none
module ssd_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 in_valid,
   output logic                                      in_stall,
   input  wire logic [11:0][ssd_pkg::CoordW-1:0]     in_coord,
   input  wire logic                                 q_full,
   output logic                                      q_push,
   output ssd_pkg::item_type                         q_word
);
   localparam int PW = 2 * ssd_pkg::VecW;

   logic               v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic               fen;
   ssd_pkg::vecs_type  vec1_ff, vec1_in, vec2_ff, vec3_ff;
   logic [4:0][2:0][PW-1:0] prod_ff, prod_in;
   logic [4:0][ssd_pkg::DotW-1:0] dot_ff, dot_in;

   function automatic logic signed [ssd_pkg::VecW-1:0] sx(input logic [31:0] x);
      sx = $signed({x[31], x});
   endfunction

   assign fen      = !(v3_ff && q_full);
   assign in_stall = !fen;
   assign v1_in    = in_valid;
   assign v2_in    = v1_ff;
   assign v3_in    = v2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vec1_in.u[i] = ssd_pkg::VecW'(sx(in_coord[3+i]) - sx(in_coord[i]));
         vec1_in.v[i] = ssd_pkg::VecW'(sx(in_coord[9+i]) - sx(in_coord[6+i]));
         vec1_in.w[i] = ssd_pkg::VecW'(sx(in_coord[i]) - sx(in_coord[6+i]));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[ssd_pkg::DotA][i] = PW'($signed(vec1_ff.u[i]) * $signed(vec1_ff.u[i]));
         prod_in[ssd_pkg::DotB][i] = PW'($signed(vec1_ff.u[i]) * $signed(vec1_ff.v[i]));
         prod_in[ssd_pkg::DotC][i] = PW'($signed(vec1_ff.v[i]) * $signed(vec1_ff.v[i]));
         prod_in[ssd_pkg::DotD][i] = PW'($signed(vec1_ff.u[i]) * $signed(vec1_ff.w[i]));
         prod_in[ssd_pkg::DotE][i] = PW'($signed(vec1_ff.v[i]) * $signed(vec1_ff.w[i]));
      end
   end

   always_comb begin
      for (int k = 0; k < 5; k++) begin
         dot_in[k] = ssd_pkg::DotW'($signed(prod_ff[k][0]))
                   + ssd_pkg::DotW'($signed(prod_ff[k][1]))
                   + ssd_pkg::DotW'($signed(prod_ff[k][2]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (fen) begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fen) begin
         vec1_ff <= vec1_in;
         vec2_ff <= vec1_ff;
         vec3_ff <= vec2_ff;
         prod_ff <= prod_in;
         dot_ff  <= dot_in;
      end
   end

   assign q_push     = v3_ff && !q_full;
   assign q_word.vec = vec3_ff;
   assign q_word.dot = dot_ff;
endmodule
`default_nettype wire

[sv/ssd_queue.sv]
// short fifo of vector and dot-product words between front and back
`default_nettype none
module ssd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ssd_pkg::item_type push_word,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output ssd_pkg::item_type      pop_word
);
   localparam int AW = $clog2(ssd_pkg::QueueDepth);

   ssd_pkg::item_type mem_ff [ssd_pkg::QueueDepth];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign full    = cnt_ff == (AW+1)'(ssd_pkg::QueueDepth);
   assign empty   = cnt_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign wp_in   = do_push ? wp_ff + 1'b1 : wp_ff;
   assign rp_in   = do_pop ? rp_ff + 1'b1 : rp_ff;
   assign cnt_in  = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   assign pop_word = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= push_word;
   end
endmodule
`default_nettype wire

[sv/ssd_back.sv]
// back end: clamping, pipelined dividers, difference vector and pipelined square root
`default_nettype none
module ssd_back #(
   parameter int FRAC_BITS = 16,
   parameter int EPS_FIXED = 655
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_empty,
   output logic                            q_pop,
   input  wire ssd_pkg::item_type          q_word,
   output logic                            out_valid,
   input  wire logic                       out_stall,
   output logic [ssd_pkg::DistW-1:0]       out_distance
);
   localparam int W   = ssd_pkg::WideW;
   localparam int QB  = ssd_pkg::QBits;
   localparam int RW  = ssd_pkg::RootW;
   localparam int SW  = W - 2 * QB;
   localparam int PW  = 70;
   localparam int HW  = PW / 2;
   localparam int NST = 7 + QB + 4 + RW + 1;
   localparam logic signed [W-1:0] Tol = W'(EPS_FIXED) <<< (3 * FRAC_BITS);
   localparam logic signed [W-1:0] One = W'(1) <<< (4 * FRAC_BITS);

   typedef struct packed {
      logic [2*HW-1:0] hh;
      logic [2*HW:0]   hl, lh;
      logic [2*HW-1:0] ll;
   } pp_type;

   typedef struct packed {
      ssd_pkg::vecs_type vec;
      logic [W-1:0] a, b, c, d, e;
   } base_type;

   typedef struct packed {
      base_type     base;
      logic [W-1:0] dd;
      pp_type [3:0] pp;
   } mp_type;

   typedef struct packed {
      base_type          base;
      logic [W-1:0]      dd;
      logic [3:0][W-1:0] pr;
   } pr_type;

   typedef struct packed {
      ssd_pkg::vecs_type vec;
      logic [W-1:0] a, b, c, d, e, dd, sn, tn;
      logic par;
   } st12_type;

   typedef struct packed {
      ssd_pkg::vecs_type vec;
      logic [W-1:0] a, b, d, sn, sd, tn, td;
   } st3_type;

   typedef struct packed {
      ssd_pkg::vecs_type vec;
      logic [W-1:0] srem, sden, trem, tden;
      logic [QB-1:0] sq, tq;
      logic [QB:0]   sfix, tfix;
      logic          suse, tuse;
   } dv_type;

   typedef struct packed {
      logic [SW-1:0] s;
      logic [RW-1:0] r;
      logic [2*RW-1:0] r2;
   } rt_type;

   logic            be;
   logic [NST-1:0]  v_ff, v_in;
   mp_type          m1_ff, m1_in, m2_ff, m2_in;
   pr_type          p1_ff, p1_in, p2_ff, p2_in;
   st12_type        s2_ff, s2_in;
   st3_type         s3_ff, s3_in;
   dv_type          dv_ff [QB+1];
   dv_type          dv_in [QB+1];
   logic [2:0][PW-1:0] p_ff, p_in;
   pp_type [2:0]       sqp_ff, sqp_in;
   logic [2:0][W-1:0]  sq_ff, sq_in;
   rt_type          rt_ff [RW+1];
   rt_type          rt_in [RW+1];
   logic [ssd_pkg::DistW-1:0] dist_ff, dist_in;

   function automatic logic signed [W-1:0] wx(input logic [ssd_pkg::DotW-1:0] x);
      wx = W'($signed(x));
   endfunction

   function automatic logic [PW-1:0] px(input logic [ssd_pkg::DotW-1:0] x);
      px = PW'($signed(x));
   endfunction

   // signed product split into four half-width partial products
   function automatic pp_type mparts(input logic [PW-1:0] x, input logic [PW-1:0] y);
      logic signed [HW:0] xl, yl;
      pp_type r;
      xl   = $signed({1'b0, x[HW-1:0]});
      yl   = $signed({1'b0, y[HW-1:0]});
      r.hh = $signed(x[PW-1:HW]) * $signed(y[PW-1:HW]);
      r.hl = $signed(x[PW-1:HW]) * yl;
      r.lh = xl * $signed(y[PW-1:HW]);
      r.ll = x[HW-1:0] * y[HW-1:0];
      mparts = r;
   endfunction

   function automatic logic [W-1:0] msum(input pp_type p);
      msum = (W'($signed(p.hh)) <<< (2 * HW)) + (W'($signed(p.hl)) <<< HW)
           + (W'($signed(p.lh)) <<< HW) + W'(p.ll);
   endfunction

   assign be    = !(out_valid && out_stall);
   assign q_pop = be && !q_empty;
   assign v_in  = {v_ff[NST-2:0], q_pop};

   // dot products in, partial products of a*c and b*b
   always_comb begin
      m1_in          = '0;
      m1_in.base.vec = q_word.vec;
      m1_in.base.a   = wx(q_word.dot[ssd_pkg::DotA]);
      m1_in.base.b   = wx(q_word.dot[ssd_pkg::DotB]);
      m1_in.base.c   = wx(q_word.dot[ssd_pkg::DotC]);
      m1_in.base.d   = wx(q_word.dot[ssd_pkg::DotD]);
      m1_in.base.e   = wx(q_word.dot[ssd_pkg::DotE]);
      m1_in.pp[0]    = mparts(px(q_word.dot[ssd_pkg::DotA]), px(q_word.dot[ssd_pkg::DotC]));
      m1_in.pp[1]    = mparts(px(q_word.dot[ssd_pkg::DotB]), px(q_word.dot[ssd_pkg::DotB]));
   end

   always_comb begin
      p1_in       = '0;
      p1_in.base  = m1_ff.base;
      p1_in.pr[0] = msum(m1_ff.pp[0]);
      p1_in.pr[1] = msum(m1_ff.pp[1]);
   end

   // determinant, partial products of the numerators
   always_comb begin
      m2_in       = '0;
      m2_in.base  = p1_ff.base;
      m2_in.dd    = p1_ff.pr[0] - p1_ff.pr[1];
      m2_in.pp[0] = mparts(p1_ff.base.b[PW-1:0], p1_ff.base.e[PW-1:0]);
      m2_in.pp[1] = mparts(p1_ff.base.c[PW-1:0], p1_ff.base.d[PW-1:0]);
      m2_in.pp[2] = mparts(p1_ff.base.a[PW-1:0], p1_ff.base.e[PW-1:0]);
      m2_in.pp[3] = mparts(p1_ff.base.b[PW-1:0], p1_ff.base.d[PW-1:0]);
   end

   always_comb begin
      p2_in      = '0;
      p2_in.base = m2_ff.base;
      p2_in.dd   = m2_ff.dd;
      for (int k = 0; k < 4; k++) p2_in.pr[k] = msum(m2_ff.pp[k]);
   end

   // numerators and near-parallel test
   always_comb begin
      logic signed [W-1:0] ad;
      s2_in     = '0;
      s2_in.vec = p2_ff.base.vec;
      s2_in.a   = p2_ff.base.a;
      s2_in.b   = p2_ff.base.b;
      s2_in.c   = p2_ff.base.c;
      s2_in.d   = p2_ff.base.d;
      s2_in.e   = p2_ff.base.e;
      s2_in.dd  = p2_ff.dd;
      s2_in.sn  = p2_ff.pr[0] - p2_ff.pr[1];
      s2_in.tn  = p2_ff.pr[2] - p2_ff.pr[3];
      ad        = $signed(p2_ff.dd) < 0 ? -$signed(p2_ff.dd) : $signed(p2_ff.dd);
      s2_in.par = ad < Tol;
   end

   // first clamp of s
   always_comb begin
      s3_in.vec = s2_ff.vec;
      s3_in.a   = s2_ff.a;
      s3_in.b   = s2_ff.b;
      s3_in.d   = s2_ff.d;
      if (s2_ff.par) begin
         s3_in.sn = '0;
         s3_in.sd = One;
         s3_in.tn = $signed(s2_ff.e) <<< (2 * FRAC_BITS);
         s3_in.td = $signed(s2_ff.c) <<< (2 * FRAC_BITS);
      end else begin
         s3_in.sn = s2_ff.sn;
         s3_in.sd = s2_ff.dd;
         s3_in.tn = s2_ff.tn;
         s3_in.td = s2_ff.dd;
         if ($signed(s2_ff.sn) < 0) begin
            s3_in.sn = '0;
            s3_in.tn = $signed(s2_ff.e) <<< (2 * FRAC_BITS);
            s3_in.td = $signed(s2_ff.c) <<< (2 * FRAC_BITS);
         end else if ($signed(s2_ff.sn) > $signed(s2_ff.dd)) begin
            s3_in.sn = s2_ff.dd;
            s3_in.tn = ($signed(s2_ff.e) + $signed(s2_ff.b)) <<< (2 * FRAC_BITS);
            s3_in.td = $signed(s2_ff.c) <<< (2 * FRAC_BITS);
         end
      end
   end

   // t clamp, s recompute and divider setup
   always_comb begin
      logic signed [W-1:0] sn, sd, tn, td, edg, an, at;
      logic clamp;
      sn    = $signed(s3_ff.sn);
      sd    = $signed(s3_ff.sd);
      tn    = $signed(s3_ff.tn);
      td    = $signed(s3_ff.td);
      edg   = '0;
      clamp = 1'b0;
      if (tn < 0) begin
         tn    = '0;
         edg   = -$signed(s3_ff.d);
         clamp = 1'b1;
      end else if (tn > td) begin
         tn    = td;
         edg   = $signed(s3_ff.b) - $signed(s3_ff.d);
         clamp = 1'b1;
      end
      if (clamp) begin
         if (edg < 0) begin
            sn = '0;
         end else if (edg > $signed(s3_ff.a)) begin
            sn = sd;
         end else begin
            sn = edg <<< (2 * FRAC_BITS);
            sd = $signed(s3_ff.a) <<< (2 * FRAC_BITS);
         end
      end
      an = sn < 0 ? -sn : sn;
      at = tn < 0 ? -tn : tn;
      dv_in[0]     = '0;
      dv_in[0].vec = s3_ff.vec;
      dv_in[0].sden = W'(1);
      dv_in[0].tden = W'(1);
      if (an < Tol || sn <= 0 || sd <= 0) begin
         dv_in[0].sfix = '0;
      end else if (sn >= sd) begin
         dv_in[0].sfix = (QB+1)'(1) << QB;
      end else begin
         dv_in[0].suse = 1'b1;
         dv_in[0].srem = sn;
         dv_in[0].sden = sd;
      end
      if (at < Tol || tn <= 0 || td <= 0) begin
         dv_in[0].tfix = '0;
      end else if (tn >= td) begin
         dv_in[0].tfix = (QB+1)'(1) << QB;
      end else begin
         dv_in[0].tuse = 1'b1;
         dv_in[0].trem = tn;
         dv_in[0].tden = td;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < QB; k++) begin : g_div
      always_comb begin
         logic [W:0] rs, rt;
         dv_in[k+1] = dv_ff[k];
         rs = {dv_ff[k].srem, 1'b0};
         rt = {dv_ff[k].trem, 1'b0};
         if (rs >= {1'b0, dv_ff[k].sden}) begin
            dv_in[k+1].srem = W'(rs - {1'b0, dv_ff[k].sden});
            dv_in[k+1].sq   = {dv_ff[k].sq[QB-2:0], 1'b1};
         end else begin
            dv_in[k+1].srem = W'(rs);
            dv_in[k+1].sq   = {dv_ff[k].sq[QB-2:0], 1'b0};
         end
         if (rt >= {1'b0, dv_ff[k].tden}) begin
            dv_in[k+1].trem = W'(rt - {1'b0, dv_ff[k].tden});
            dv_in[k+1].tq   = {dv_ff[k].tq[QB-2:0], 1'b1};
         end else begin
            dv_in[k+1].trem = W'(rt);
            dv_in[k+1].tq   = {dv_ff[k].tq[QB-2:0], 1'b0};
         end
      end
   end

   // difference vector components
   always_comb begin
      logic [QB:0] sc, tc;
      sc = dv_ff[QB].suse ? {1'b0, dv_ff[QB].sq} : dv_ff[QB].sfix;
      tc = dv_ff[QB].tuse ? {1'b0, dv_ff[QB].tq} : dv_ff[QB].tfix;
      for (int i = 0; i < 3; i++) begin
         p_in[i] = (PW'($signed(dv_ff[QB].vec.w[i])) <<< QB)
                 + $signed({1'b0, sc}) * $signed(dv_ff[QB].vec.u[i])
                 - $signed({1'b0, tc}) * $signed(dv_ff[QB].vec.v[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sqp_in[i] = mparts(p_ff[i], p_ff[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = msum(sqp_ff[i]);
      end
   end

   always_comb begin
      logic [W-1:0] sum;
      sum      = sq_ff[0] + sq_ff[1] + sq_ff[2];
      rt_in[0] = '0;
      rt_in[0].s = sum[W-1:2*QB];
   end

   // square root, one result bit per stage
   for (genvar k = 0; k < RW; k++) begin : g_root
      localparam int Bit = RW - 1 - k;
      always_comb begin
         logic [2*RW-1:0] cand;
         rt_in[k+1] = rt_ff[k];
         cand = rt_ff[k].r2 + ((2*RW)'(rt_ff[k].r) << (Bit + 1))
              + ((2*RW)'(1) << (2 * Bit));
         if (SW'(cand) <= rt_ff[k].s) begin
            rt_in[k+1].r  = rt_ff[k].r | (RW'(1) << Bit);
            rt_in[k+1].r2 = cand;
         end
      end
   end

   always_comb begin
      if (|rt_ff[RW].r[RW-1:ssd_pkg::DistW]) dist_in = '1;
      else dist_in = rt_ff[RW].r[ssd_pkg::DistW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (be) v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (be) begin
         m1_ff <= m1_in;
         p1_ff <= p1_in;
         m2_ff <= m2_in;
         p2_ff <= p2_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         for (int k = 0; k <= QB; k++) dv_ff[k] <= dv_in[k];
         p_ff   <= p_in;
         sqp_ff <= sqp_in;
         sq_ff  <= sq_in;
         for (int k = 0; k <= RW; k++) rt_ff[k] <= rt_in[k];
         dist_ff <= dist_in;
      end
   end

   assign out_valid    = v_ff[NST-1];
   assign out_distance = dist_ff;
endmodule
`default_nettype wire

[sv/segment_segment_distance.sv]
// top level of the segment-to-segment distance block
//
// takes one word per cycle on the req_ channel: two 3-d segments as twelve
// signed q16.16 coordinates; a word is taken when req_valid is high and
// req_stall is low. each word gives one rsp_ word, the truncated minimum
// distance as unsigned q18.16, taken when rsp_valid is high and rsp_stall low.
// sustained rate is one word per cycle while rsp_stall is low. a word passes
// the front registers, the queue memory and the back pipeline; most back
// stages are the 32-step divider pipeline and the 36-step square root pipeline,
// others split the wide products into partial products and their sums.
// words leave in arrival order. when rsp_stall holds, the back end freezes with
// its result on rsp_; the front takes words until the 4-word queue is full and
// a word waits at its output, then raises req_stall. reset is synchronous and
// empties every stage and the queue; no result appears before a word is taken.
`default_nettype none
module segment_segment_distance #(
   parameter int FRAC_BITS = 16,
   parameter int EPS_FIXED = 655
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_a_start_x,
   input  wire logic [31:0] req_a_start_y,
   input  wire logic [31:0] req_a_start_z,
   input  wire logic [31:0] req_a_end_x,
   input  wire logic [31:0] req_a_end_y,
   input  wire logic [31:0] req_a_end_z,
   input  wire logic [31:0] req_b_start_x,
   input  wire logic [31:0] req_b_start_y,
   input  wire logic [31:0] req_b_start_z,
   input  wire logic [31:0] req_b_end_x,
   input  wire logic [31:0] req_b_end_y,
   input  wire logic [31:0] req_b_end_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [33:0]      rsp_distance
);
   logic [11:0][ssd_pkg::CoordW-1:0] coord;
   logic q_full, q_push;
   ssd_pkg::item_type push_word, pop_word;
   logic q_empty, q_pop;

   assign coord = {req_b_end_z, req_b_end_y, req_b_end_x,
                   req_b_start_z, req_b_start_y, req_b_start_x,
                   req_a_end_z, req_a_end_y, req_a_end_x,
                   req_a_start_z, req_a_start_y, req_a_start_x};

   ssd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_coord (coord),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_word   (push_word)
   );

   ssd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_word  (pop_word)
   );

   ssd_back #(
      .FRAC_BITS (FRAC_BITS),
      .EPS_FIXED (EPS_FIXED)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_pop        (q_pop),
      .q_word       (pop_word),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_distance (rsp_distance)
   );
endmodule
`default_nettype wire

[sv/ssd_checker.sv]
// port-level checker for the segment-to-segment distance block
`default_nettype none
module ssd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [33:0] rsp_distance
);
   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance))
      else $error("stalled result changed");

   // reset empties the pipeline
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a result rises only after reset has been released
   a_rise_late: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset) && !$past(reset, 2))
      else $error("result too soon after reset");

   // no result shows up before any word could have passed the front end
   a_no_phantom: assert property (@(posedge clock)
      $past(reset, 3) && $past(reset, 2) && $past(reset) && !reset |-> !rsp_valid)
      else $error("result without an accepted word");

   // req_valid, req_stall and rsp_valid stay known out of reset
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_valid, req_stall, rsp_valid}))
      else $error("unknown handshake line");
endmodule

bind segment_segment_distance ssd_checker u_ssd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_distance (rsp_distance)
);
`default_nettype wire
